[rtl/ltc_pkg.sv]
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types and constants of the prefix tautology checker: character codes,
// sequencer states, verdict codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package ltc_pkg;

	// Character codes of the expression alphabet.
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_AND     = 8'h43;
	localparam logic [7:0] CH_OR      = 8'h44;
	localparam logic [7:0] CH_IMPLIES = 8'h49;
	localparam logic [7:0] CH_IFF     = 8'h45;
	localparam logic [7:0] CH_NOT     = 8'h4E;

	// Letters a to z, and the width of a variable number.
	localparam int unsigned LETTERS = 26;
	localparam int unsigned LETTER_W = 5;
	localparam int unsigned VAR_W = 5;

	// Widths of the result fields.
	localparam int unsigned COUNT_W = 27;
	localparam int unsigned OUT_DATA_W = 64;

	typedef enum logic [1:0] {
		VERDICT_TAUTOLOGY     = 2'd0,
		VERDICT_CONTRADICTION = 2'd1,
		VERDICT_CONTINGENCY   = 2'd2
	} verdict_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS,
		ST_FETCH,
		ST_SYM,
		ST_POPA,
		ST_POPB,
		ST_END,
		ST_TALLY,
		ST_DONE
	} state_t;

	// One entry of the letter map.
	typedef struct packed {
		logic             assigned;
		logic             over;
		logic [VAR_W-1:0] idx;
	} map_entry_t;

	// Decoded kind of an operator symbol.
	typedef struct packed {
		logic binary;
		logic pushes;
	} op_info_t;

endpackage

[rtl/prefix_logic_tautology_checker.sv]
// ----------------------------------------------------------------------------
// prefix_logic_tautology_checker
// Truth-table tautology check of a prefix propositional expression.
// ----------------------------------------------------------------------------
// Characters load at one per cycle into the expression store. After the
// character marked last, the block walks all 2^n assignments of the n
// variables, evaluating the expression right to left on a one-bit stack held
// in a RAM with registered read, and then delivers one result. Each pass fetches
// every character from the last back to the first and tallies the stack top; a
// variable is pushed, N or a discarding character pops one value (N pushes it
// back inverted) and a binary operator pops two, all through the single stack
// RAM. Input is not accepted during evaluation; characters of the next expression
// load while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module prefix_logic_tautology_checker #(
	parameter int unsigned MAX_LENGTH    = 128,
	parameter int unsigned STACK_DEPTH   = 128,
	parameter int unsigned MAX_VARIABLES = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // [1:0] verdict, [28:2] true_count,
	                                   // [55:29] false_count,
	                                   // [60:56] variable_count,
	                                   // [61] malformed, [63:62] zero
);

	localparam int unsigned LW  = $clog2(MAX_LENGTH + 1);
	localparam int unsigned LAW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int unsigned SW  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned VW  = $clog2(MAX_VARIABLES + 1);
	localparam int unsigned AW  = MAX_VARIABLES;
	localparam int unsigned CW  = MAX_VARIABLES + 1;
	localparam int unsigned CNT_W = ltc_pkg::COUNT_W;

	ltc_pkg::state_t state_q, state_d;
	logic [LW-1:0]   len_q, len_d;
	logic [LW-1:0]   k_q, k_d;
	logic [SW-1:0]   sp_q, sp_d;
	logic [VW-1:0]   vars_q, vars_d;
	logic            err_q, err_d;
	logic [AW-1:0]   assign_q, assign_d;
	logic [CW-1:0]   true_q, true_d;
	logic [CW-1:0]   false_q, false_d;
	logic [7:0]      op_q, op_d;
	logic            a_q, a_d;
	logic            under_q, under_d;
	logic            top_q, top_d;

	logic                out_valid_q;
	logic [1:0]          out_verdict_q;
	logic [CNT_W-1:0]    out_true_q;
	logic [CNT_W-1:0]    out_false_q;
	logic [4:0]          out_vars_q;
	logic                out_bad_q;
	logic                out_load;
	ltc_pkg::verdict_t   verdict;

	// Expression store and stack ports.
	logic            expr_we;
	logic [LAW-1:0]  expr_waddr;
	logic [LAW-1:0]  expr_raddr;
	logic [7:0]      expr_rdata;
	logic            stk_we;
	logic [SAW-1:0]  stk_waddr;
	logic            stk_wdata;
	logic [SAW-1:0]  stk_raddr;
	logic            stk_rdata;

	// Letter map ports.
	logic                         map_clear;
	logic                         map_we;
	logic [ltc_pkg::LETTER_W-1:0] map_waddr;
	logic                         map_wover;
	logic [ltc_pkg::VAR_W-1:0]    map_widx;
	logic [ltc_pkg::LETTER_W-1:0] map_raddr;
	ltc_pkg::map_entry_t          map_entry;

	// Evaluation unit ports.
	ltc_pkg::op_info_t op_info;
	logic              eval_b;
	logic              eval_result;

	logic            in_accept;
	logic [7:0]      cur_sym;
	logic            cur_letter;
	logic [AW-1:0]   assign_shift;
	logic            var_value;
	logic            pop_val;
	logic            last_pass;
	logic [AW:0]     assign_next;
	logic [AW:0]     pass_total;

	ltc_ram #(.WIDTH(8), .DEPTH(MAX_LENGTH)) u_expr_ram (
		.clk   (clk),
		.we    (expr_we),
		.waddr (expr_waddr),
		.wdata (s_axis_tdata),
		.raddr (expr_raddr),
		.rdata (expr_rdata)
	);

	ltc_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	ltc_letter_map u_letter_map (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (map_clear),
		.we     (map_we),
		.waddr  (map_waddr),
		.wover  (map_wover),
		.widx   (map_widx),
		.raddr  (map_raddr),
		.rentry (map_entry)
	);

	ltc_eval_unit u_eval_unit (
		.op     (op_q),
		.a      (a_q),
		.b      (eval_b),
		.info   (op_info),
		.result (eval_result)
	);

	// Handshake and symbol selection.
	assign s_axis_tready = (state_q == ltc_pkg::ST_LOAD);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cur_sym       = (state_q == ltc_pkg::ST_SYM) ? expr_rdata : s_axis_tdata;
	assign cur_letter    = (cur_sym >= ltc_pkg::CH_LOWER_A) &&
	                       (cur_sym <= ltc_pkg::CH_LOWER_Z);
	assign map_raddr     = ltc_pkg::LETTER_W'(cur_sym - ltc_pkg::CH_LOWER_A);

	// Value of a mapped variable under the current assignment.
	assign assign_shift = assign_q >> map_entry.idx;
	assign var_value    = map_entry.assigned && !map_entry.over && assign_shift[0];

	// Popped value, false on underflow; second operand for the unit.
	assign pop_val = !under_q && stk_rdata;
	assign eval_b  = pop_val;

	// Pass bookkeeping.
	assign assign_next = {1'b0, assign_q} + (AW+1)'(1);
	assign pass_total  = (AW+1)'(1) << vars_q;
	assign last_pass   = (assign_next == pass_total);

	// Sequencer: next state, datapath registers and memory ports.
	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		k_d        = k_q;
		sp_d       = sp_q;
		vars_d     = vars_q;
		err_d      = err_q;
		assign_d   = assign_q;
		true_d     = true_q;
		false_d    = false_q;
		op_d       = op_q;
		a_d        = a_q;
		under_d    = under_q;
		top_d      = top_q;
		expr_we    = 1'b0;
		expr_waddr = LAW'(len_q);
		expr_raddr = LAW'(k_q - LW'(1));
		stk_we     = 1'b0;
		stk_waddr  = SAW'(sp_q);
		stk_wdata  = 1'b0;
		stk_raddr  = SAW'(sp_q - SW'(1));
		map_clear  = 1'b0;
		map_we     = 1'b0;
		map_waddr  = map_raddr;
		map_wover  = 1'b0;
		map_widx   = ltc_pkg::VAR_W'(vars_q);
		out_load   = 1'b0;

		case (state_q)
			ltc_pkg::ST_LOAD: begin
				if (in_accept) begin
					if (s_axis_tdata > ltc_pkg::CH_LOWER_Z) begin
						err_d = 1'b1;
					end
					if (len_q < LW'(MAX_LENGTH)) begin
						expr_we = 1'b1;
						len_d   = len_q + LW'(1);
						// First appearance of a letter takes the next number.
						if (cur_letter && !map_entry.assigned) begin
							map_we = 1'b1;
							if (vars_q < VW'(MAX_VARIABLES)) begin
								vars_d = vars_q + VW'(1);
							end else begin
								map_wover = 1'b1;
								err_d     = 1'b1;
							end
						end
					end else begin
						err_d = 1'b1;
					end
					if (s_axis_tlast) begin
						true_d   = '0;
						false_d  = '0;
						assign_d = '0;
						state_d  = ltc_pkg::ST_PASS;
					end
				end
			end

			ltc_pkg::ST_PASS: begin
				k_d     = len_q;
				sp_d    = '0;
				state_d = ltc_pkg::ST_FETCH;
			end

			ltc_pkg::ST_FETCH: begin
				if (k_q == '0) begin
					state_d = ltc_pkg::ST_END;
				end else begin
					k_d     = k_q - LW'(1);
					state_d = ltc_pkg::ST_SYM;
				end
			end

			ltc_pkg::ST_SYM: begin
				if (cur_letter) begin
					// Push the variable's value.
					if (sp_q >= SW'(STACK_DEPTH)) begin
						err_d = 1'b1;
					end else begin
						stk_we    = 1'b1;
						stk_wdata = var_value;
						sp_d      = sp_q + SW'(1);
					end
					state_d = ltc_pkg::ST_FETCH;
				end else begin
					// Pop the first operand.
					op_d = expr_rdata;
					if (sp_q == '0) begin
						err_d   = 1'b1;
						under_d = 1'b1;
					end else begin
						under_d = 1'b0;
						sp_d    = sp_q - SW'(1);
					end
					state_d = ltc_pkg::ST_POPA;
				end
			end

			ltc_pkg::ST_POPA: begin
				a_d = pop_val;
				if (op_info.binary) begin
					// Pop the second operand.
					if (sp_q == '0) begin
						err_d   = 1'b1;
						under_d = 1'b1;
					end else begin
						under_d = 1'b0;
						sp_d    = sp_q - SW'(1);
					end
					state_d = ltc_pkg::ST_POPB;
				end else begin
					if (op_info.pushes) begin
						if (sp_q >= SW'(STACK_DEPTH)) begin
							err_d = 1'b1;
						end else begin
							stk_we    = 1'b1;
							stk_wdata = ~pop_val;
							sp_d      = sp_q + SW'(1);
						end
					end
					state_d = ltc_pkg::ST_FETCH;
				end
			end

			ltc_pkg::ST_POPB: begin
				if (sp_q >= SW'(STACK_DEPTH)) begin
					err_d = 1'b1;
				end else begin
					stk_we    = 1'b1;
					stk_wdata = eval_result;
					sp_d      = sp_q + SW'(1);
				end
				state_d = ltc_pkg::ST_FETCH;
			end

			ltc_pkg::ST_END: begin
				// Exactly one value must remain; read the top of the stack.
				if (sp_q != SW'(1)) begin
					err_d = 1'b1;
				end
				top_d   = (sp_q != '0);
				state_d = ltc_pkg::ST_TALLY;
			end

			ltc_pkg::ST_TALLY: begin
				if (top_q && stk_rdata) begin
					true_d = true_q + CW'(1);
				end else begin
					false_d = false_q + CW'(1);
				end
				if (last_pass) begin
					state_d = ltc_pkg::ST_DONE;
				end else begin
					assign_d = assign_next[AW-1:0];
					state_d  = ltc_pkg::ST_PASS;
				end
			end

			ltc_pkg::ST_DONE: begin
				// Hand the result over and clear for the next expression.
				if (!out_valid_q || m_axis_tready) begin
					out_load  = 1'b1;
					len_d     = '0;
					vars_d    = '0;
					err_d     = 1'b0;
					map_clear = 1'b1;
					state_d   = ltc_pkg::ST_LOAD;
				end
			end

			default: begin
				state_d = ltc_pkg::ST_LOAD;
			end
		endcase
	end

	// Verdict from the tallies.
	always_comb begin
		if (false_q == '0) begin
			verdict = ltc_pkg::VERDICT_TAUTOLOGY;
		end else if (true_q == '0) begin
			verdict = ltc_pkg::VERDICT_CONTRADICTION;
		end else begin
			verdict = ltc_pkg::VERDICT_CONTINGENCY;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ltc_pkg::ST_LOAD;
			len_q    <= '0;
			k_q      <= '0;
			sp_q     <= '0;
			vars_q   <= '0;
			err_q    <= 1'b0;
			assign_q <= '0;
			true_q   <= '0;
			false_q  <= '0;
			under_q  <= 1'b0;
			top_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			len_q    <= len_d;
			k_q      <= k_d;
			sp_q     <= sp_d;
			vars_q   <= vars_d;
			err_q    <= err_d;
			assign_q <= assign_d;
			true_q   <= true_d;
			false_q  <= false_d;
			under_q  <= under_d;
			top_q    <= top_d;
		end
	end

	// Operand payload registers.
	always_ff @(posedge clk) begin
		op_q <= op_d;
		a_q  <= a_d;
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_verdict_q <= verdict;
			out_true_q    <= CNT_W'(true_q);
			out_false_q   <= CNT_W'(false_q);
			out_vars_q    <= 5'(vars_q);
			out_bad_q     <= err_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_bad_q, out_vars_q, out_false_q, out_true_q,
	                        out_verdict_q};

	// The stack never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n) sp_q <= SW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// The outcome counts of a fresh result cover every assignment.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load |=> ({1'b0, out_true_q} + {1'b0, out_false_q}) ==
			((CNT_W+1)'(1) << out_vars_q)))
		else $error("true and false counts do not sum to 2^n");

	// A tautology verdict comes with no false outcome.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_verdict_q == ltc_pkg::VERDICT_TAUTOLOGY) |-> out_false_q == '0)
		else $error("tautology reported with false outcomes");

	// A pending result is never overwritten before it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result overwritten while pending");

endmodule

[rtl/ltc_ram.sv]
// ----------------------------------------------------------------------------
// ltc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ltc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/ltc_letter_map.sv]
// ----------------------------------------------------------------------------
// ltc_letter_map
// Maps the letters a to z to variable numbers in order of first appearance.
// Each letter has a valid bit that the clear input or reset drops at once.
// ----------------------------------------------------------------------------
module ltc_letter_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clear,
	input  logic                         we,
	input  logic [ltc_pkg::LETTER_W-1:0] waddr,
	input  logic                         wover,
	input  logic [ltc_pkg::VAR_W-1:0]    widx,
	input  logic [ltc_pkg::LETTER_W-1:0] raddr,
	output ltc_pkg::map_entry_t          rentry
);

	localparam int unsigned LETTER_W = ltc_pkg::LETTER_W;

	logic [ltc_pkg::LETTERS-1:0] valid_q;
	logic [ltc_pkg::LETTERS-1:0] over_q;
	logic [ltc_pkg::VAR_W-1:0]   idx_q [ltc_pkg::LETTERS];

	// Valid bits are control state and reset at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (we && (waddr < LETTER_W'(ltc_pkg::LETTERS))) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Payload of each entry.
	always_ff @(posedge clk) begin
		if (we && (waddr < LETTER_W'(ltc_pkg::LETTERS))) begin
			over_q[waddr] <= wover;
			idx_q[waddr]  <= widx;
		end
	end

	// Lookup; a letter not yet seen reads as unassigned.
	always_comb begin
		rentry = '0;
		if (raddr < LETTER_W'(ltc_pkg::LETTERS) && valid_q[raddr]) begin
			rentry.assigned = 1'b1;
			rentry.over     = over_q[raddr];
			rentry.idx      = idx_q[raddr];
		end
	end

endmodule

[rtl/ltc_eval_unit.sv]
// ----------------------------------------------------------------------------
// ltc_eval_unit
// The shared logic unit of the evaluator: decodes an operator symbol and
// combines the popped operands into the value pushed back.
// ----------------------------------------------------------------------------
module ltc_eval_unit (
	input  logic [7:0]        op,
	input  logic              a,
	input  logic              b,
	output ltc_pkg::op_info_t info,
	output logic              result
);

	// Operator decode and truth function.
	always_comb begin
		info   = '0;
		result = 1'b0;
		case (op)
			ltc_pkg::CH_AND: begin
				info   = '{binary: 1'b1, pushes: 1'b1};
				result = a & b;
			end
			ltc_pkg::CH_OR: begin
				info   = '{binary: 1'b1, pushes: 1'b1};
				result = a | b;
			end
			ltc_pkg::CH_IMPLIES: begin
				info   = '{binary: 1'b1, pushes: 1'b1};
				result = ~a | b;
			end
			ltc_pkg::CH_IFF: begin
				info   = '{binary: 1'b1, pushes: 1'b1};
				result = ~(a ^ b);
			end
			ltc_pkg::CH_NOT: begin
				info   = '{binary: 1'b0, pushes: 1'b1};
				result = ~a;
			end
			default: begin
				// Any other character only discards one value.
				info   = '{binary: 1'b0, pushes: 1'b0};
				result = 1'b0;
			end
		endcase
	end

endmodule
